/* src/i2cms_pkg.sv */
// Shared types, constants and phase decode helpers for the I2C master bit sequencer.
// Depends on nothing; used by i2cms_step and i2c_master_bit_sequencer.
package i2cms_pkg;

  // Command codes carried by the kind field and held as the active command.
  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // Command lengths in bus phases.
  localparam logic [4:0] LEN_START     = 5'd3;
  localparam logic [4:0] LEN_STOP      = 5'd2;
  localparam logic [4:0] LEN_WRITE     = 5'd27;
  localparam logic [4:0] LEN_READ_ACK  = 5'd20;
  localparam logic [4:0] LEN_READ_NACK = 5'd21;
  localparam logic [4:0] LEN_OTHER     = 5'd1;

  // Phase landmarks inside the write and read sequences.
  localparam logic [4:0] PH_WRITE_DATA_END   = 5'd24;
  localparam logic [4:0] PH_WRITE_ACK_CLK    = 5'd25;
  localparam logic [4:0] PH_WRITE_ACK_SAMPLE = 5'd26;
  localparam logic [4:0] PH_READ_FIRST_SAMPLE = 5'd2;
  localparam logic [4:0] PH_READ_LAST_BIT    = 5'd16;
  localparam logic [4:0] PH_READ_ACK_DRIVE   = 5'd17;
  localparam logic [4:0] PH_READ_ACK_CLK     = 5'd18;
  localparam logic [4:0] PH_READ_NACK_CLK    = 5'd19;

  // Line levels, 1 means released high.
  typedef struct packed {
    logic sda;
    logic scl;
  } pins_t;

  // Sequencer state carried from one beat to the next.
  typedef struct packed {
    logic [4:0] phase_count;
    cmd_t       active_command;
    logic [7:0] shift_byte;
    logic       ack_choice;
    pins_t      pin_levels;
    logic       nack_seen;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase_count:    5'd0,
    active_command: CMD_IDLE,
    shift_byte:     8'd0,
    ack_choice:     1'b0,
    pin_levels:     '{sda: 1'b1, scl: 1'b1},
    nack_seen:      1'b0
  };

  // One result beat.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       last_phase;
    logic [7:0] read_data;
    logic       no_ack;
    logic       busy_res;
  } result_t;

  // Each data bit of a write spans three phases; this picks the bit driven in phase p.
  function automatic logic [2:0] write_bit_index(input logic [4:0] p);
    logic [2:0] idx;
    case (p) inside
      [5'd0:5'd2]:   idx = 3'd7;
      [5'd3:5'd5]:   idx = 3'd6;
      [5'd6:5'd8]:   idx = 3'd5;
      [5'd9:5'd11]:  idx = 3'd4;
      [5'd12:5'd14]: idx = 3'd3;
      [5'd15:5'd17]: idx = 3'd2;
      [5'd18:5'd20]: idx = 3'd1;
      default:       idx = 3'd0;
    endcase
    return idx;
  endfunction

  // SCL is high in the middle phase of each three-phase write bit.
  function automatic logic write_clk_high(input logic [4:0] p);
    logic hi;
    case (p) inside
      5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: hi = 1'b1;
      default: hi = 1'b0;
    endcase
    return hi;
  endfunction

endpackage

/* src/i2cms_step.sv */
// Combinational phase step: next sequencer state and result beat for one item.
// Depends on i2cms_pkg for the command codes, phase constants and structs.
module i2cms_step (
  input  i2cms_pkg::state_t  state,
  input  logic [2:0]         kind,
  input  logic [7:0]         data_byte,
  input  logic               send_ack,
  input  logic               sda_in,
  output i2cms_pkg::state_t  state_next,
  output i2cms_pkg::result_t result
);
  import i2cms_pkg::*;

  logic       is_idle;
  logic       new_cmd;
  cmd_t       cmd;
  logic [4:0] p;
  logic [7:0] shift;
  logic       ackc;
  logic       nack;
  pins_t      pins;
  logic [4:0] len;
  logic       last;

  assign is_idle = (state.active_command == CMD_IDLE);
  assign new_cmd = is_idle && (kind == CMD_START || kind == CMD_STOP ||
                               kind == CMD_WRITE || kind == CMD_READ);

  // Effective command context: either a freshly started command or the running one.
  always_comb begin
    cmd   = state.active_command;
    p     = state.phase_count;
    shift = state.shift_byte;
    ackc  = state.ack_choice;
    nack  = state.nack_seen;
    if (new_cmd) begin
      cmd  = cmd_t'(kind);
      p    = 5'd0;
      nack = 1'b0;
      if (kind == CMD_WRITE) begin
        shift = data_byte;
      end else if (kind == CMD_READ) begin
        shift = 8'd0;
        ackc  = send_ack;
      end
    end
    // Read bits come in MSB first, one on each item after a high SCL phase.
    if (cmd == CMD_READ && p >= PH_READ_FIRST_SAMPLE && p <= PH_READ_LAST_BIT && !p[0]) begin
      shift = {shift[6:0], sda_in};
    end
    // The slave acknowledge is sampled on the item after the acknowledge clock phase.
    if (cmd == CMD_WRITE && p == PH_WRITE_ACK_SAMPLE) begin
      nack = sda_in;
    end
  end

  // Pin levels for the current phase.
  always_comb begin
    pins = '{sda: 1'b1, scl: 1'b0};
    unique case (cmd)
      CMD_START: begin
        pins.sda = (p == 5'd0);
        pins.scl = (p != 5'd2);
      end
      CMD_STOP: begin
        pins.sda = (p != 5'd0);
        pins.scl = 1'b1;
      end
      CMD_WRITE: begin
        if (p < PH_WRITE_DATA_END) begin
          pins.sda = shift[write_bit_index(p)];
          pins.scl = write_clk_high(p);
        end else begin
          pins.scl = (p == PH_WRITE_ACK_CLK);
        end
      end
      CMD_READ: begin
        if (p == 5'd0) begin
          pins.scl = 1'b0;
        end else if (p <= PH_READ_LAST_BIT) begin
          pins.scl = p[0];
        end else if (p == PH_READ_ACK_DRIVE) begin
          pins.sda = 1'b0;
        end else if (ackc) begin
          pins.sda = 1'b0;
          pins.scl = (p == PH_READ_ACK_CLK);
        end else begin
          pins.scl = (p == PH_READ_NACK_CLK);
        end
      end
      default: pins = '{sda: 1'b1, scl: 1'b0};
    endcase
  end

  // Command length decoder.
  always_comb begin
    unique case (cmd)
      CMD_START: len = LEN_START;
      CMD_STOP:  len = LEN_STOP;
      CMD_WRITE: len = LEN_WRITE;
      CMD_READ:  len = ackc ? LEN_READ_ACK : LEN_READ_NACK;
      default:   len = LEN_OTHER;
    endcase
  end

  assign last = (p == len - 5'd1);

  // Result beat and next state.
  always_comb begin
    state_next = state;
    result     = '0;
    if (is_idle && !new_cmd) begin
      // Idle tick: hold the pins and report nothing.
      result.scl_level = state.pin_levels.scl;
      result.sda_level = state.pin_levels.sda;
    end else begin
      state_next.shift_byte = shift;
      state_next.ack_choice = ackc;
      state_next.nack_seen  = nack;
      state_next.pin_levels = pins;
      result.scl_level      = pins.scl;
      result.sda_level      = pins.sda;
      result.last_phase     = last;
      result.busy_res       = !last;
      if (last) begin
        state_next.active_command = CMD_IDLE;
        state_next.phase_count    = 5'd0;
        if (cmd == CMD_READ) begin
          result.read_data = shift;
        end
        if (cmd == CMD_WRITE) begin
          result.no_ack = nack;
        end
      end else begin
        state_next.active_command = cmd;
        state_next.phase_count    = p + 5'd1;
      end
    end
  end

endmodule

/* src/i2c_master_bit_sequencer.sv */
// Top level of the I2C master bit sequencer: input register, state, result register.
// Depends on i2cms_pkg and i2cms_step.
//
// Usage: each input beat (kind, data_byte, send_ack, sda_in) yields exactly one
// result beat holding the SCL and SDA levels to drive for one bus phase.
// While idle, kind selects start (3 phases), stop (2), write byte (27) or read
// byte (20 with ACK, 21 with NACK); any other kind is an idle tick that holds
// the pins. While a command runs, every beat advances it by one phase and its
// kind and data are ignored. sda_in must carry the SDA level sampled during the
// phase driven by the previous result. last_phase marks a command's final phase,
// where read_data (read) or no_ack (write) are valid; busy_res is 1 while phases
// remain.
// A beat accepted into the input register is stepped when the result register is
// free or being drained, and its result is then held in the result register.
// Throughput: one beat per cycle while the receiver takes results; the step is one
// pass of logic between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops only when both are full.
// Reset (rst, synchronous) empties both registers, makes the sequencer idle and
// sets the held pin levels of both lines to released high.
module i2c_master_bit_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] kind,
  input  logic [7:0] data_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_level,
  output logic       sda_level,
  output logic       last_phase,
  output logic [7:0] read_data,
  output logic       no_ack,
  output logic       busy_res
);
  import i2cms_pkg::*;

  logic       in_full;
  logic [2:0] kind_q;
  logic [7:0] data_byte_q;
  logic       send_ack_q;
  logic       sda_in_q;
  logic       advance;
  state_t     state;
  state_t     state_next;
  result_t    result_next;
  result_t    result;

  // The held beat moves on whenever the result register is free or being drained.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  i2cms_step u_step (
    .state      (state),
    .kind       (kind_q),
    .data_byte  (data_byte_q),
    .send_ack   (send_ack_q),
    .sda_in     (sda_in_q),
    .state_next (state_next),
    .result     (result_next)
  );

  // Control flags and sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      state     <= STATE_RESET;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers on both sides.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q      <= kind;
      data_byte_q <= data_byte;
      send_ack_q  <= send_ack;
      sda_in_q    <= sda_in;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign scl_level  = result.scl_level;
  assign sda_level  = result.sda_level;
  assign last_phase = result.last_phase;
  assign read_data  = result.read_data;
  assign no_ack     = result.no_ack;
  assign busy_res   = result.busy_res;

endmodule
